// ----- rtl/bmhq_pkg.sv -----
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary min-heap priority queue.
// ----------------------------------------------------------------------------
package bmhq_pkg;

    localparam int unsigned CAPACITY_DEF = 255;
    localparam int unsigned SYM_W        = 8;
    localparam int unsigned REF_W        = 9;
    localparam int unsigned PRIO_W       = 31;
    localparam int unsigned CNT_W        = 8;
    localparam int unsigned ENTRY_W      = SYM_W + 2 * REF_W + PRIO_W;
    localparam int unsigned IN_DATA_W    = 72;
    localparam int unsigned OUT_DATA_W   = 72;

    localparam logic [PRIO_W-1:0] INF = '1;

    typedef enum logic [1:0] {
        CMD_INSERT  = 2'd0,
        CMD_EXTRACT = 2'd1,
        CMD_DECKEY  = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BAD   = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [REF_W-1:0]  rref;
        logic [REF_W-1:0]  lref;
        logic [SYM_W-1:0]  sym;
    } t_entry;

endpackage

// ----- rtl/binary_min_heap_queue.sv -----
// ----------------------------------------------------------------------------
// binary_min_heap_queue
// One-based binary min-heap in a single synchronous memory; insert, extract
// minimum and decrease key, one command at a time, one result word each.
// ----------------------------------------------------------------------------
// latency, accept to result valid, is set by the steps: errors go straight to the result;
// decrease key reads the entry first; insert and decrease key sift up, parent by parent;
// extract reads the last and root entries, then sifts down, reading both children per level
// throughput: one command at a time, set by the single-port heap memory and the
// level-by-level sift walk; next word taken the cycle after the result is registered
// reset: synchronous active low; clears the entry count and control state only
module binary_min_heap_queue #(
    parameter int unsigned CAPACITY = bmhq_pkg::CAPACITY_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // tdata: command[1:0], symbol[9:2], left_ref[18:10], right_ref[27:19],
    //        priority_req[58:28], position[66:59], zero fill
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [bmhq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tdata: status[1:0], out_symbol[9:2], out_left_ref[18:10],
    //        out_right_ref[27:19], out_priority[58:28], entry_count[66:59], zero fill
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [bmhq_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import bmhq_pkg::*;

    localparam int unsigned AW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC_RD, S_DEC_CHK, S_UP_RD, S_UP_CMP, S_UP_WR,
        S_EX_RD, S_EX_ROOT, S_DN_RDL, S_DN_RDR, S_DN_CMP, S_DN_WR, S_DONE
    } t_state;

    // heap memory, one port, registered read
    t_entry  r_mem [1:CAPACITY];
    t_entry  r_rd;
    logic    mem_we;
    logic [AW-1:0] mem_addr;
    t_entry  mem_wd;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wd;
        end
        r_rd <= r_mem[mem_addr];
    end

    t_state        r_state;
    logic [AW-1:0] r_cnt, r_pos, r_chd;
    t_entry        r_cur, r_res, r_cl, r_best;
    logic          r_bsel;
    logic [1:0]    r_status;
    logic [OUT_DATA_W-1:0] r_tdata;
    logic          r_ovalid;

    // input fields
    logic [1:0]        in_cmd;
    logic [PRIO_W-1:0] in_prio;
    logic [7:0]        in_pos;
    t_entry            in_ent;
    assign in_cmd       = s_axis_tdata[1:0];
    assign in_ent.sym   = s_axis_tdata[9:2];
    assign in_ent.lref  = s_axis_tdata[18:10];
    assign in_ent.rref  = s_axis_tdata[27:19];
    assign in_ent.prio  = s_axis_tdata[58:28];
    assign in_prio      = s_axis_tdata[58:28];
    assign in_pos       = s_axis_tdata[66:59];

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_tdata;

    logic [AW:0]   lft, rgt;
    logic [AW-1:0] par;
    assign lft = {r_pos, 1'b0};
    assign rgt = {r_pos, 1'b1};
    assign par = r_pos >> 1;

    // memory port control
    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_pos;
        mem_wd   = r_cur;
        case (r_state)
            S_UP_RD:   mem_addr = par;
            S_UP_WR:   mem_we = 1'b1;
            S_EX_RD:   mem_addr = r_cnt;
            S_EX_ROOT: mem_addr = AW'(1);
            S_DN_RDL:  mem_addr = lft[AW-1:0];
            S_DN_RDR:  mem_addr = rgt[AW-1:0];
            S_DN_WR: begin
                mem_we = 1'b1;
                mem_wd = r_best;
            end
            default:   mem_addr = r_pos;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && r_state != S_DONE) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid && s_axis_tready) begin
                        r_res    <= '0;
                        r_status <= ST_BAD;
                        r_state  <= S_DONE;
                        case (t_cmd'(in_cmd))
                            CMD_INSERT: begin
                                if (r_cnt >= AW'(CAPACITY)) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_status <= ST_OK;
                                    r_res    <= in_ent;
                                    r_cur    <= in_ent;
                                    r_cnt    <= r_cnt + 1'b1;
                                    r_pos    <= r_cnt + 1'b1;
                                    r_state  <= S_UP_RD;
                                end
                            end
                            CMD_EXTRACT: begin
                                if (r_cnt == '0) begin
                                    r_status <= ST_EMPTY;
                                end else begin
                                    r_status <= ST_OK;
                                    r_state  <= S_EX_RD;
                                end
                            end
                            CMD_DECKEY: begin
                                if (in_pos != '0 && 32'(in_pos) <= 32'(r_cnt)) begin
                                    r_pos       <= AW'(in_pos);
                                    r_cur.prio  <= in_prio;
                                    r_state     <= S_DEC_RD;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_DEC_RD: r_state <= S_DEC_CHK;
                S_DEC_CHK: begin
                    if (r_cur.prio < r_rd.prio) begin
                        r_cur    <= '{prio: r_cur.prio, rref: r_rd.rref,
                                      lref: r_rd.lref, sym: r_rd.sym};
                        r_res    <= '{prio: r_cur.prio, rref: r_rd.rref,
                                      lref: r_rd.lref, sym: r_rd.sym};
                        r_status <= ST_OK;
                        r_state  <= S_UP_RD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                // sift up: read parent, move it down if larger
                S_UP_RD: begin
                    r_state <= (r_pos > AW'(1)) ? S_UP_CMP : S_UP_WR;
                end
                S_UP_CMP: begin
                    if (r_rd.prio > r_cur.prio) begin
                        r_best  <= r_rd;
                        r_state <= S_DN_WR;
                        r_bsel  <= 1'b1;
                    end else begin
                        r_state <= S_UP_WR;
                    end
                end
                S_UP_WR: r_state <= S_DONE;
                // extract: take last, then root
                S_EX_RD: r_state <= S_EX_ROOT;
                S_EX_ROOT: begin
                    r_cur   <= r_rd;
                    r_cnt   <= r_cnt - 1'b1;
                    r_pos   <= AW'(1);
                    r_state <= S_DN_RDL;
                end
                S_DN_RDL: begin
                    // root read lands here on the first step only
                    if (r_pos == AW'(1)) begin
                        r_res <= r_rd;
                    end
                    r_state <= (lft <= {1'b0, r_cnt}) ? S_DN_RDR : S_UP_WR;
                end
                S_DN_RDR: begin
                    r_cl    <= r_rd;
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: begin
                    if (rgt <= {1'b0, r_cnt} && r_rd.prio < r_cl.prio
                        && r_rd.prio < r_cur.prio) begin
                        r_best  <= r_rd;
                        r_chd   <= rgt[AW-1:0];
                        r_state <= S_DN_WR;
                    end else if (r_cl.prio < r_cur.prio) begin
                        r_best  <= r_cl;
                        r_chd   <= lft[AW-1:0];
                        r_state <= S_DN_WR;
                    end else begin
                        r_state <= S_UP_WR;
                    end
                    r_bsel <= 1'b0;
                end
                // write moved entry at current position, step on
                S_DN_WR: begin
                    if (r_bsel) begin
                        r_pos   <= par;
                        r_state <= S_UP_RD;
                    end else begin
                        r_pos   <= r_chd;
                        r_state <= S_DN_RDL;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_tdata  <= OUT_DATA_W'({CNT_W'(r_cnt), r_res.prio, r_res.rref,
                                                 r_res.lref, r_res.sym, r_status});
                        r_ovalid <= 1'b1;
                        r_bsel   <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
